FILE: rtl/ncsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsd_pkg: shared types and helpers for the nixie clock set/display block
// Event and page codes, item and result records, decimal digit split and
// one-hot tube encoding.
// ----------------------------------------------------------------------------
package ncsd_pkg;

	localparam int DIGIT_LINES  = 10;
	localparam int TUBE_COUNT   = 4;
	localparam int FRAME_W      = DIGIT_LINES * TUBE_COUNT;

	localparam int HOUR_W       = 5;
	localparam int MINUTE_W     = 6;
	localparam int LAST_MIN_W   = 7;
	localparam int COUNT_W      = 8;
	localparam int INTERVAL_W   = 8;
	localparam int TENS_W       = 3;

	localparam int HOURS_PER_DAY   = 24;
	localparam int MINUTES_PER_HR  = 60;

	localparam logic [HOUR_W-1:0]     HOUR_MAX       = HOUR_W'(HOURS_PER_DAY - 1);
	localparam logic [MINUTE_W-1:0]   MINUTE_MAX     = MINUTE_W'(MINUTES_PER_HR - 1);
	localparam logic [LAST_MIN_W-1:0] LAST_MIN_RESET = LAST_MIN_W'(100);
	localparam logic [COUNT_W-1:0]    COUNT_RESET    = COUNT_W'(255);
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);

	// Stream and register port widths
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// Register map (word index taken from paddr[2])
	typedef enum logic {
		REG_CATHODE_INTERVAL = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_SAMPLE = 3'd0,
		OP_MODE   = 3'd1,
		OP_INC    = 3'd2,
		OP_DEC    = 3'd3,
		OP_BLINK  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PAGE_IDLE   = 2'd0,
		PAGE_HOUR   = 2'd1,
		PAGE_MINUTE = 2'd2
	} page_t;

	typedef struct packed {
		logic [2:0]          operation;
		logic [HOUR_W-1:0]   sample_hour;
		logic [MINUTE_W-1:0] sample_minute;
	} item_t;

	typedef struct packed {
		logic                frame_valid;
		logic [FRAME_W-1:0]  tube_frame;
		logic                hour_led;
		logic                minute_led;
		logic                cathode_request;
		logic                rtc_write;
		logic [HOUR_W-1:0]   write_hour;
		logic [MINUTE_W-1:0] write_minute;
		logic [1:0]          menu_page;
	} result_t;

	// Tens digit of a value below 64, by threshold compares
	function automatic logic [TENS_W-1:0] tens_of(input logic [MINUTE_W-1:0] v);
		logic [TENS_W-1:0] t;
		t = '0;
		for (int k = 1; k <= 6; k++) begin
			if (v >= MINUTE_W'(10 * k)) t = TENS_W'(k);
		end
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [MINUTE_W-1:0] v);
		logic [MINUTE_W-1:0] rest;
		rest = v - (MINUTE_W'(tens_of(v)) * MINUTE_W'(10));
		return rest[3:0];
	endfunction

	function automatic logic [DIGIT_LINES-1:0] one_hot(input logic [3:0] d);
		return DIGIT_LINES'(1) << d;
	endfunction

	// Four tubes, minute units in the low slot
	function automatic logic [FRAME_W-1:0] build_frame(
		input logic [HOUR_W-1:0]   h,
		input logic [MINUTE_W-1:0] m
	);
		logic [MINUTE_W-1:0] hw;
		hw = MINUTE_W'(h);
		return {one_hot(4'(tens_of(hw))), one_hot(units_of(hw)),
			one_hot(4'(tens_of(m))), one_hot(units_of(m))};
	endfunction

endpackage

FILE: rtl/ncsd_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsd_apb_regs: configuration register file
// Holds the cathode refresh interval, written and read over APB.
// ----------------------------------------------------------------------------
module ncsd_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ncsd_pkg::PADDR_W-1:0]  paddr,
	input  logic [ncsd_pkg::PDATA_W-1:0]  pwdata,
	output logic [ncsd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [ncsd_pkg::INTERVAL_W-1:0] cathode_interval
);
	import ncsd_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	logic [INTERVAL_W-1:0] interval_q;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Capture the interval on a completed write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (wr_en && idx == REG_CATHODE_INTERVAL) begin
			interval_q <= pwdata[INTERVAL_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (idx == REG_CATHODE_INTERVAL) prdata = PDATA_W'(interval_q);
	end

	assign cathode_interval = interval_q;

endmodule

FILE: rtl/ncsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsd_core: clock state and event processing
// Holds page, shown time, blink phase and minute counter; computes the
// result of one event and the next state in a single pass.
// ----------------------------------------------------------------------------
module ncsd_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  ncsd_pkg::item_t                   item,
	input  logic [ncsd_pkg::INTERVAL_W-1:0]   cathode_interval,
	output ncsd_pkg::result_t                 result
);
	import ncsd_pkg::*;

	page_t                 page_q, page_d;
	logic [LAST_MIN_W-1:0] last_min_q, last_min_d;
	logic [COUNT_W-1:0]    count_q, count_d, count_inc;
	logic [HOUR_W-1:0]     hour_q, hour_d;
	logic [MINUTE_W-1:0]   minute_q, minute_d;
	logic                  blink_q, blink_d;
	logic [HOUR_W:0]       hour_up;
	logic [MINUTE_W:0]     minute_up;
	logic                  frame, cathode, wr;

	assign count_inc = count_q + COUNT_W'(1);
	assign hour_up   = {1'b0, hour_q} + (HOUR_W+1)'(1);
	assign minute_up = {1'b0, minute_q} + (MINUTE_W+1)'(1);

	// Next state and pulses for one event
	always_comb begin
		page_d     = page_q;
		last_min_d = last_min_q;
		count_d    = count_q;
		hour_d     = hour_q;
		minute_d   = minute_q;
		blink_d    = blink_q;
		frame      = 1'b0;
		cathode    = 1'b0;
		wr         = 1'b0;
		unique case (page_q)
			PAGE_IDLE: begin
				if (item.operation == OP_SAMPLE) begin
					hour_d   = item.sample_hour;
					minute_d = item.sample_minute;
					if (last_min_q != LAST_MIN_W'(item.sample_minute)) begin
						last_min_d = LAST_MIN_W'(item.sample_minute);
						frame      = 1'b1;
						if (count_inc == cathode_interval) begin
							count_d = '0;
							cathode = 1'b1;
						end else begin
							count_d = count_inc;
						end
					end
				end else if (item.operation == OP_MODE) begin
					page_d = PAGE_HOUR;
					frame  = 1'b1;
				end
			end
			PAGE_HOUR, PAGE_MINUTE: begin
				if (item.operation <= OP_BLINK) begin
					unique case (item.operation)
						OP_MODE: begin
							if (page_q == PAGE_HOUR) begin
								page_d = PAGE_MINUTE;
							end else begin
								wr     = 1'b1;
								page_d = PAGE_IDLE;
							end
						end
						OP_INC: begin
							if (page_q == PAGE_HOUR) begin
								hour_d = (hour_up >= (HOUR_W+1)'(HOURS_PER_DAY))
									? HOUR_W'(hour_up - (HOUR_W+1)'(HOURS_PER_DAY))
									: hour_up[HOUR_W-1:0];
							end else begin
								minute_d = (minute_up >= (MINUTE_W+1)'(MINUTES_PER_HR))
									? MINUTE_W'(minute_up - (MINUTE_W+1)'(MINUTES_PER_HR))
									: minute_up[MINUTE_W-1:0];
							end
						end
						OP_DEC: begin
							if (page_q == PAGE_HOUR) begin
								hour_d = (hour_q == '0) ? HOUR_MAX : hour_q - HOUR_W'(1);
							end else begin
								minute_d = (minute_q == '0) ? MINUTE_MAX
									: minute_q - MINUTE_W'(1);
							end
						end
						OP_BLINK: blink_d = ~blink_q;
						default: ;
					endcase
					frame = (page_d != PAGE_IDLE);
				end
			end
			default: ;
		endcase
	end

	// Assemble the result from the updated state
	always_comb begin
		result                 = '0;
		result.frame_valid     = frame;
		result.tube_frame      = frame ? build_frame(hour_d, minute_d) : '0;
		result.hour_led        = (page_d == PAGE_HOUR) && blink_d;
		result.minute_led      = (page_d == PAGE_MINUTE) && blink_d;
		result.cathode_request = cathode;
		result.rtc_write       = wr;
		result.write_hour      = wr ? hour_q : '0;
		result.write_minute    = wr ? minute_q : '0;
		result.menu_page       = page_d;
	end

	// Commit state when an event is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q     <= PAGE_IDLE;
			last_min_q <= LAST_MIN_RESET;
			count_q    <= COUNT_RESET;
			hour_q     <= '0;
			minute_q   <= '0;
			blink_q    <= 1'b1;
		end else if (step) begin
			page_q     <= page_d;
			last_min_q <= last_min_d;
			count_q    <= count_d;
			hour_q     <= hour_d;
			minute_q   <= minute_d;
			blink_q    <= blink_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_wr_leaves_menu: assert property (@(posedge clk) disable iff (!arst_n)
		result.rtc_write |-> (result.menu_page == PAGE_IDLE) && !result.frame_valid)
		else $error("rtc write without return to idle");

	a_cathode_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.cathode_request |=> count_q == '0)
		else $error("minute counter not cleared after cathode request");

	a_cathode_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.cathode_request |-> result.frame_valid && page_q == PAGE_IDLE)
		else $error("cathode request without new-minute frame");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(page_q) && $stable(count_q) && $stable(hour_q))
		else $error("state changed without an event");

	a_frame_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result.frame_valid |-> $onehot(result.tube_frame[DIGIT_LINES-1:0]))
		else $error("minute units digit not one-hot");
`endif

endmodule

FILE: rtl/nixie_clock_set_and_display_top.sv
`timescale 1ns / 1ps
// Each event passes through the input register, then the result register,
// before the earliest transfer of its result.
// Throughput: 1 event per cycle while the master side takes results.
// Reset (arst_n low) empties both registers, selects the idle page, sets the
// refresh interval to 10 and the minute counter to 255, blink phase to 1.
// ----------------------------------------------------------------------------
// nixie_clock_set_and_display_top: nixie clock set and display controller
// Event stream in, one result per event out, APB for the refresh interval.
// ----------------------------------------------------------------------------
module nixie_clock_set_and_display_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ncsd_pkg::PADDR_W-1:0]       paddr,
	input  logic [ncsd_pkg::PDATA_W-1:0]       pwdata,
	output logic [ncsd_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	// Event stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ncsd_pkg::S_TDATA_W-1:0]     s_tdata, // [4:0] sample_hour, [10:5] sample_minute
	input  logic [ncsd_pkg::S_TUSER_W-1:0]     s_tuser, // [2:0] operation
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [39:0] tube_frame, [40] hour_led, [41] minute_led, [42] cathode_request,
	// [47:43] write_hour, [53:48] write_minute, [55:54] menu_page
	output logic [ncsd_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [ncsd_pkg::M_TUSER_W-1:0]     m_tuser  // [0] frame_valid, [1] rtc_write
);
	import ncsd_pkg::*;

	logic [INTERVAL_W-1:0] interval;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb, res_s2;
	logic    valid_s2;
	logic    advance, step;

	ncsd_apb_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.cathode_interval (interval)
	);

	// Result register frees when empty or taken this cycle
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation     <= s_tuser[2:0];
			item_s1.sample_hour   <= s_tdata[4:0];
			item_s1.sample_minute <= s_tdata[10:5];
		end
	end

	ncsd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.item             (item_s1),
		.cathode_interval (interval),
		.result           (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_s2 <= res_comb;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.menu_page, res_s2.write_minute, res_s2.write_hour,
		res_s2.cathode_request, res_s2.minute_led, res_s2.hour_led, res_s2.tube_frame};
	assign m_tuser  = {res_s2.rtc_write, res_s2.frame_valid};

endmodule
